@@ hdl/gcrdm_pkg.sv @@
// ----------------------------------------------------------------------------
// gcrdm_pkg
// Shared widths, register indexes, codes and sequencer states for the
// Geiger count-rate and dose-rate monitor.
// ----------------------------------------------------------------------------
package gcrdm_pkg;

	localparam int LOG_DEPTH_DEF = 16;

	// field widths
	localparam int CNT_W  = 16;
	localparam int TOT_W  = 32;
	localparam int UP_W   = 32;
	localparam int TUBE_W = 16;
	localparam int THR_W  = 24;
	localparam int WSUM_W = 20;
	localparam int CPM_W  = 28;
	localparam int DOSE_W = 28;
	localparam int LVL_W  = 2;
	localparam int CFG_AW = 2;
	localparam int CFG_DW = 24;

	// fixed point: UQ24.4 CPM, UQ20.8 dose
	localparam int FRAC_W      = 4;
	localparam int SEC_PER_MIN = 60;
	localparam int CPM_SCALE   = SEC_PER_MIN * (1 << FRAC_W);
	localparam int PROD_W      = TOT_W + 10;

	// divider: quotient bits per division and step counter width
	localparam int DIV_STEPS = 28;
	localparam int STEP_W    = $clog2(DIV_STEPS);

	localparam logic [WSUM_W-1:0] WSUM_MAX = '1;
	localparam logic [CPM_W-1:0]  CPM_MAX  = '1;
	localparam logic [DOSE_W-1:0] DOSE_MAX = '1;

	// register indexes
	localparam logic [CFG_AW-1:0] REG_TUBE_INDEX = 2'd0;
	localparam logic [CFG_AW-1:0] REG_ALARM_LOW  = 2'd1;
	localparam logic [CFG_AW-1:0] REG_ALARM_HIGH = 2'd2;

	// register reset values
	localparam logic [TUBE_W-1:0] TUBE_INDEX_RST = 16'd151;
	localparam logic [THR_W-1:0]  ALARM_LOW_RST  = 24'd100;
	localparam logic [THR_W-1:0]  ALARM_HIGH_RST = 24'd1000;

	// request types
	localparam logic REQ_PULSE = 1'b0;
	localparam logic REQ_TICK  = 1'b1;

	// alarm levels
	localparam logic [LVL_W-1:0] LVL_NONE = 2'd0;
	localparam logic [LVL_W-1:0] LVL_LOW  = 2'd1;
	localparam logic [LVL_W-1:0] LVL_HIGH = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CPM_LOAD,
		ST_CPM_CHK,
		ST_CPM_DIV,
		ST_DOSE_LOAD,
		ST_DOSE_CHK,
		ST_DOSE_DIV,
		ST_FINISH
	} state_t;

endpackage

@@ hdl/gcrdm_req_if.sv @@
// ----------------------------------------------------------------------------
// gcrdm_req_if
// Request channel: tube pulse or end-of-period tick with uptime.
// ----------------------------------------------------------------------------
interface gcrdm_req_if;
	import gcrdm_pkg::*;

	logic            valid;
	logic            ready;
	logic            req_type;
	logic [UP_W-1:0] uptime_s;

	modport source (output valid, req_type, uptime_s, input ready);
	modport sink   (input valid, req_type, uptime_s, output ready);
endinterface

@@ hdl/gcrdm_rsp_if.sv @@
// ----------------------------------------------------------------------------
// gcrdm_rsp_if
// Result channel: window sum, CPM, dose rate, alarm level, saturation flag.
// ----------------------------------------------------------------------------
interface gcrdm_rsp_if;
	import gcrdm_pkg::*;

	logic              valid;
	logic              ready;
	logic [WSUM_W-1:0] window_sum;
	logic [CPM_W-1:0]  cpm_total;
	logic [DOSE_W-1:0] dose_rate;
	logic [LVL_W-1:0]  alarm_level;
	logic              rate_saturated;

	modport source (output valid, window_sum, cpm_total, dose_rate, alarm_level,
		rate_saturated, input ready);
	modport sink   (input valid, window_sum, cpm_total, dose_rate, alarm_level,
		rate_saturated, output ready);
endinterface

@@ hdl/gcrdm_cfg_if.sv @@
// ----------------------------------------------------------------------------
// gcrdm_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface gcrdm_cfg_if;
	import gcrdm_pkg::*;

	logic              valid;
	logic              ready;
	logic [CFG_AW-1:0] addr;
	logic [CFG_DW-1:0] data;

	modport source (output valid, addr, data, input ready);
	modport sink   (input valid, addr, data, output ready);
endinterface

@@ hdl/geiger_count_rate_dose_monitor.sv @@
// ----------------------------------------------------------------------------
// geiger_count_rate_dose_monitor
// Counts tube pulses per log period and, on each period tick, reports the
// windowed count, extrapolated CPM, dose rate and alarm level.
// ----------------------------------------------------------------------------
// Usage:
//   req  - one transaction per event. req_type REQ_PULSE bumps the period
//          count (saturating). REQ_TICK closes the period
//          and produces exactly one rsp transaction; uptime_s is read then.
//   rsp  - window_sum, cpm_total (UQ24.4), dose_rate (UQ20.8), alarm_level,
//          rate_saturated. Held in an output register until taken.
//   cfg  - register writes (0 tube_index, 1 alarm_low_cpm, 2 alarm_high_cpm),
//          always ready; other indexes are dropped. Write only while idle.
// Sequence: after a tick is accepted, the sequencer loads total*960 into the
//   divider, checks it for overflow and runs 28 restoring steps for CPM, then
//   loads and checks the dose dividend and runs 28 steps for the dose, all on
//   one shared 34-bit subtractor, before the result goes into the output
//   register. A clamped division skips its 28 steps. req.ready is low until
//   the sequencer is idle again, so no request is taken while a tick is in
//   progress; pulses go at one per cycle otherwise.
// Stall: a finished result waits in the sequencer only if the previous one is
//   still unread; new requests are taken while a result sits in rsp.
// Reset: all counts, the running window sum and the log fill count clear;
//   registers return to 151 / 100 / 1000. The log RAM is not cleared: entries
//   are ignored until written, tracked by a fill count.
// ----------------------------------------------------------------------------
module geiger_count_rate_dose_monitor #(
	parameter int LOG_DEPTH = gcrdm_pkg::LOG_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	gcrdm_cfg_if.sink   cfg,
	gcrdm_req_if.sink   req,
	gcrdm_rsp_if.source rsp
);
	import gcrdm_pkg::*;

	localparam int AW = $clog2(LOG_DEPTH);
	// running sum of LOG_DEPTH-1 entries, plus headroom for the add
	localparam int SW = CNT_W + AW;
	localparam int XW = (SW > WSUM_W) ? SW : WSUM_W;
	localparam logic [AW-1:0] PTR_LAST = AW'(LOG_DEPTH - 1);

	// ---------------- state and registers ----------------
	state_t state_q, state_d;

	logic [TUBE_W-1:0] tube_q;
	logic [THR_W-1:0]  alarm_low_q;
	logic [THR_W-1:0]  alarm_high_q;

	logic [CNT_W-1:0]  period_q;
	logic [TOT_W-1:0]  total_q;
	logic [SW-1:0]     sum_q;     // sum of newest LOG_DEPTH-1 logged periods
	logic [AW-1:0]     wp_q;      // next log slot to write
	logic [AW-1:0]     fill_q;    // ticks so far, saturates at LOG_DEPTH-1
	logic              ovalid_q;

	// log memory
	logic [CNT_W-1:0]  log_mem [LOG_DEPTH];
	logic [CNT_W-1:0]  rd_q;      // oldest entry of the window, leaving it

	// datapath
	logic [CNT_W-1:0]  pc_q;      // period count just closed
	logic [WSUM_W-1:0] win_q;
	logic [CPM_W-1:0]  cpm_q;
	logic              sat_q;
	logic [UP_W-1:0]   dvsr_q;    // divisor: uptime, then tube index
	logic [UP_W-1:0]   rem_q;     // partial remainder, below the divisor while dividing
	logic [DIV_STEPS-1:0] dvd_q;  // dividend low bits in, quotient bits out
	logic [STEP_W-1:0] cnt_q;

	// output payload
	logic [WSUM_W-1:0] o_win_q;
	logic [CPM_W-1:0]  o_cpm_q;
	logic [DOSE_W-1:0] o_dose_q;
	logic [LVL_W-1:0]  o_lvl_q;
	logic              o_sat_q;

	// ---------------- combinational ----------------
	logic req_acc, pulse_acc, tick_acc, cfg_acc;
	logic unit_step, out_load;
	logic [AW-1:0] wp_next, rd_addr;
	logic [TOT_W:0] tot_sum;
	logic [PROD_W-1:0] prod;
	logic [XW-1:0] sum_x;
	logic [WSUM_W-1:0] win_sat;
	logic [SW-1:0] drop;
	logic [LVL_W-1:0] lvl;

	// shared subtractor: compare (check states) or one restoring step
	logic [UP_W+1:0] sub_a, sub_b, sub_d;
	logic sub_ge;
	logic [UP_W-1:0] rem_step;

	assign req_acc   = req.valid && req.ready;
	assign pulse_acc = req_acc && (req.req_type == REQ_PULSE);
	assign tick_acc  = req_acc && (req.req_type == REQ_TICK);
	assign cfg_acc   = cfg.valid && cfg.ready;

	assign cfg.ready = 1'b1;

	assign wp_next = (wp_q == PTR_LAST) ? '0 : wp_q + 1'b1;
	// slot written LOG_DEPTH-1 ticks ago is the one after the write pointer
	assign rd_addr = wp_next;

	assign tot_sum = {1'b0, total_q} + (TOT_W + 1)'(period_q);
	assign prod    = PROD_W'(total_q) * PROD_W'(CPM_SCALE);

	assign sum_x   = XW'(sum_q);
	assign win_sat = (sum_x > XW'(WSUM_MAX)) ? WSUM_MAX : sum_x[WSUM_W-1:0];
	assign drop    = (fill_q == PTR_LAST) ? SW'(rd_q) : '0;

	always_comb begin
		if (unit_step) begin
			sub_a = {1'b0, rem_q, dvd_q[DIV_STEPS-1]};
		end else begin
			sub_a = {2'b00, rem_q};
		end
		sub_b    = {2'b00, dvsr_q};
		sub_d    = sub_a - sub_b;
		sub_ge   = !sub_d[UP_W+1];
		rem_step = sub_ge ? sub_d[UP_W-1:0] : sub_a[UP_W-1:0];
	end

	always_comb begin
		if (cpm_q >= {alarm_high_q, {FRAC_W{1'b0}}}) begin
			lvl = LVL_HIGH;
		end else if (cpm_q >= {alarm_low_q, {FRAC_W{1'b0}}}) begin
			lvl = LVL_LOW;
		end else begin
			lvl = LVL_NONE;
		end
	end

	// ---------------- sequencer ----------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:      if (tick_acc) state_d = ST_CPM_LOAD;
			ST_CPM_LOAD:  state_d = ST_CPM_CHK;
			ST_CPM_CHK:   state_d = sub_ge ? ST_DOSE_LOAD : ST_CPM_DIV;
			ST_CPM_DIV:   if (cnt_q == '0) state_d = ST_DOSE_LOAD;
			ST_DOSE_LOAD: state_d = ST_DOSE_CHK;
			ST_DOSE_CHK:  state_d = sub_ge ? ST_FINISH : ST_DOSE_DIV;
			ST_DOSE_DIV:  if (cnt_q == '0) state_d = ST_FINISH;
			ST_FINISH:    if (out_load) state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		req.ready = (state_q == ST_IDLE);
		unit_step = (state_q == ST_CPM_DIV) || (state_q == ST_DOSE_DIV);
		out_load  = (state_q == ST_FINISH) && (!ovalid_q || rsp.ready);
	end

	// ---------------- control registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			tube_q       <= TUBE_INDEX_RST;
			alarm_low_q  <= ALARM_LOW_RST;
			alarm_high_q <= ALARM_HIGH_RST;
			period_q     <= '0;
			total_q      <= '0;
			sum_q        <= '0;
			wp_q         <= '0;
			fill_q       <= '0;
			ovalid_q     <= 1'b0;
		end else begin
			state_q <= state_d;

			if (cfg_acc) begin
				case (cfg.addr)
					REG_TUBE_INDEX: tube_q       <= cfg.data[TUBE_W-1:0];
					REG_ALARM_LOW:  alarm_low_q  <= cfg.data[THR_W-1:0];
					REG_ALARM_HIGH: alarm_high_q <= cfg.data[THR_W-1:0];
					default:        ;
				endcase
			end

			if (pulse_acc && (period_q != '1)) begin
				period_q <= period_q + 1'b1;
			end else if (tick_acc) begin
				period_q <= '0;
			end

			if (tick_acc) begin
				total_q <= tot_sum[TOT_W] ? '1 : tot_sum[TOT_W-1:0];
				wp_q    <= wp_next;
			end

			// slide the window: new period in, oldest out once the log is full
			if (state_q == ST_CPM_LOAD) begin
				sum_q <= sum_q + SW'(pc_q) - drop;
				if (fill_q != PTR_LAST) fill_q <= fill_q + 1'b1;
			end

			if (out_load) begin
				ovalid_q <= 1'b1;
			end else if (rsp.ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	// ---------------- log memory ----------------
	always_ff @(posedge clk) begin
		if (tick_acc) begin
			log_mem[wp_q] <= period_q;
			rd_q          <= log_mem[rd_addr];
		end
	end

	// ---------------- datapath ----------------
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (tick_acc) begin
					pc_q   <= period_q;
					win_q  <= win_sat;
					dvsr_q <= req.uptime_s;
					sat_q  <= 1'b0;
				end
			end
			ST_CPM_LOAD: begin
				// total*960 split: high bits seed the remainder
				rem_q <= UP_W'(prod[PROD_W-1:DIV_STEPS]);
				dvd_q <= prod[DIV_STEPS-1:0];
				cnt_q <= STEP_W'(DIV_STEPS - 1);
			end
			ST_CPM_CHK: begin
				// quotient would exceed 28 bits, or uptime is zero
				if (sub_ge) begin
					cpm_q <= CPM_MAX;
					sat_q <= 1'b1;
				end
			end
			ST_CPM_DIV: begin
				rem_q <= rem_step;
				dvd_q <= {dvd_q[DIV_STEPS-2:0], sub_ge};
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) cpm_q <= {dvd_q[DIV_STEPS-2:0], sub_ge};
			end
			ST_DOSE_LOAD: begin
				// dividend is cpm*16
				rem_q  <= UP_W'(cpm_q[CPM_W-1:CPM_W-FRAC_W]);
				dvd_q  <= {cpm_q[CPM_W-FRAC_W-1:0], {FRAC_W{1'b0}}};
				dvsr_q <= UP_W'(tube_q);
				cnt_q  <= STEP_W'(DIV_STEPS - 1);
			end
			ST_DOSE_CHK: begin
				// dose overflow or zero tube index: clamp, flag untouched
				if (sub_ge) dvd_q <= DOSE_MAX;
			end
			ST_DOSE_DIV: begin
				rem_q <= rem_step;
				dvd_q <= {dvd_q[DIV_STEPS-2:0], sub_ge};
				cnt_q <= cnt_q - 1'b1;
			end
			ST_FINISH: begin
				if (out_load) begin
					o_win_q  <= win_q;
					o_cpm_q  <= cpm_q;
					o_dose_q <= dvd_q;
					o_lvl_q  <= lvl;
					o_sat_q  <= sat_q;
				end
			end
			default: ;
		endcase
	end

	assign rsp.valid          = ovalid_q;
	assign rsp.window_sum     = o_win_q;
	assign rsp.cpm_total      = o_cpm_q;
	assign rsp.dose_rate      = o_dose_q;
	assign rsp.alarm_level    = o_lvl_q;
	assign rsp.rate_saturated = o_sat_q;

endmodule
